>>> hw/rtl/bmvc_pkg.sv
// Package for the bipartite vertex cover block: commands, register indexes,
// controller-to-datapath command and status structs. No dependencies.
package bmvc_pkg;
  typedef enum logic [1:0] {
    CmdAddEdge  = 2'd0,
    CmdAddPair  = 2'd1,
    CmdCompute  = 2'd2,
    CmdClear    = 2'd3
  } cmd_e;

  localparam logic RegLeftCount  = 1'b0;
  localparam logic RegRightCount = 1'b1;

  typedef enum logic [2:0] {
    DpNop,
    DpLoad,
    DpStart,
    DpWalk,
    DpCount,
    DpEmit
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic scan_done;
    logic emit_last;
  } dp_status_t;
endpackage

>>> hw/rtl/bmvc_if.sv
// Valid/ready channel interfaces for items, results and register writes.
// Depends on nothing.
interface bmvc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [4:0] left_vertex;
  logic [4:0] right_vertex;
  modport source (output valid, command, left_vertex, right_vertex, input ready);
  modport sink (input valid, command, left_vertex, right_vertex, output ready);
endinterface

interface bmvc_out_if;
  logic       valid;
  logic       ready;
  logic       on_right_side;
  logic [4:0] vertex_number;
  logic [5:0] cover_size;
  logic       empty_cover;
  logic       last;
  modport source (output valid, on_right_side, vertex_number, cover_size, empty_cover,
                  last, input ready);
  modport sink (input valid, on_right_side, vertex_number, cover_size, empty_cover,
                last, output ready);
endinterface

interface bmvc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [5:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bmvc_ctrl.sv
// Controller state machine: sequences load, walk, count and emit phases.
// Depends on bmvc_pkg.
module bmvc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_cmd_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  bmvc_pkg::dp_status_t status_i,
  output bmvc_pkg::dp_cmd_t    cmd_o
);
  import bmvc_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StWalk,
    StCount,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = DpNop;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.op = DpLoad;
          if (cmd_e'(in_cmd_i) == CmdCompute) state_d = StStart;
        end
      end
      StStart: begin
        cmd_o.op = DpStart;
        state_d  = StWalk;
      end
      StWalk: begin
        cmd_o.op = DpWalk;
        if (status_i.walk_done) state_d = StCount;
      end
      StCount: begin
        cmd_o.op = DpCount;
        if (status_i.scan_done) begin
          state_d     = StEmit;
          out_valid_d = 1'b1;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          cmd_o.op = DpEmit;
          if (status_i.emit_last) begin
            out_valid_d = 1'b0;
            state_d     = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_valid_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StEmit) else $error("result valid outside emit");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_ready_o) else $error("ready while busy");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && status_i.emit_last |=> state_q == StIdle)
    else $error("last result did not end cover");
endmodule

>>> hw/rtl/bmvc_dp.sv
// Datapath: edge rows, matching, walk marks, pending-vertex walk and cover emit.
// Depends on bmvc_pkg.
module bmvc_dp #(
  parameter int MaxLeft  = 32,
  parameter int MaxRight = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmvc_pkg::dp_cmd_t    cmd_i,
  input  logic [1:0]           in_cmd_i,
  input  logic [4:0]           in_left_i,
  input  logic [4:0]           in_right_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [5:0]           cfg_data_i,
  output bmvc_pkg::dp_status_t status_o,
  output logic                 on_right_side_o,
  output logic [4:0]           vertex_number_o,
  output logic [5:0]           cover_size_o,
  output logic                 empty_cover_o,
  output logic                 last_o
);
  import bmvc_pkg::*;

  localparam int LW = (MaxLeft > 1) ? $clog2(MaxLeft) : 1;
  localparam int RW = (MaxRight > 1) ? $clog2(MaxRight) : 1;
  localparam int CW = $clog2(((MaxLeft > MaxRight) ? MaxLeft : MaxRight) + 1);
  localparam int PW = LW + 1;
  localparam int NV = MaxLeft + MaxRight;
  localparam int XW = $clog2(NV);
  localparam int TW = $clog2(NV + 1);
  localparam int OutLimit = 32;

  logic [MaxRight-1:0] edge_q [MaxLeft];
  logic [PW-1:0]       part_q [MaxRight];
  logic [MaxLeft-1:0]  lmatch_q;
  logic [MaxLeft-1:0]  vl_q;
  logic [MaxRight-1:0] vr_q;
  logic [MaxLeft-1:0]  pend_l_q;
  logic [MaxRight-1:0] pend_r_q;
  logic [CW-1:0]       lcnt_q, rcnt_q;
  logic [TW-1:0]       total_q;
  logic [5:0]          shown_q, k_q;
  logic [XW:0]         scan_q;

  logic [MaxLeft-1:0]  lvalid, lstart;
  logic [MaxRight-1:0] rvalid;
  logic [LW-1:0]       in_l;
  logic [RW-1:0]       in_r;
  logic                in_ok;
  logic [LW-1:0]       top_l;
  logic [RW-1:0]       top_r;
  logic [MaxRight-1:0] nbr;
  logic [LW-1:0]       pl;
  logic                pl_ok;
  logic [NV-1:0]       cand;
  logic [XW:0]         srch_base;
  logic [XW:0]         nxt_idx;
  logic                nxt_found;
  logic [XW:0]         cur;
  logic [CW-1:0]       cv;

  assign in_l  = LW'(in_left_i);
  assign in_r  = RW'(in_right_i);
  assign in_ok = (int'(in_left_i) < MaxLeft) && (int'(in_right_i) < MaxRight);

  always_comb begin
    for (int i = 0; i < MaxLeft; i++) lvalid[i] = (CW'(i) < lcnt_q);
    for (int i = 0; i < MaxRight; i++) rvalid[i] = (CW'(i) < rcnt_q);
    lstart = '0;
    for (int r = 0; r < MaxRight; r++)
      if (rvalid[r] && part_q[r] != '0)
        lstart[part_q[r][LW-1:0] - LW'(1)] = 1'b1;
    lstart = lvalid & ~(lmatch_q & lstart);
  end

  always_comb begin
    top_l = '0;
    for (int i = MaxLeft - 1; i >= 0; i--)
      if (pend_l_q[i]) top_l = LW'(i);
    top_r = '0;
    for (int i = MaxRight - 1; i >= 0; i--)
      if (pend_r_q[i]) top_r = RW'(i);
    nbr = '0;
    for (int r = 0; r < MaxRight; r++)
      nbr[r] = edge_q[top_l][r] && rvalid[r] && !vr_q[r] &&
               (part_q[r] != PW'(top_l) + PW'(1));
    pl    = part_q[top_r][LW-1:0] - LW'(1);
    pl_ok = (part_q[top_r] != '0) && lvalid[pl] && !vl_q[pl];
  end

  assign cand = {rvalid & vr_q, lvalid & ~vl_q};

  always_comb begin
    srch_base = (cmd_i.op == DpEmit) ? scan_q + (XW+1)'(1) : '0;
    nxt_found = 1'b0;
    nxt_idx   = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (cand[i] && (XW+1)'(i) >= srch_base) begin
        nxt_found = 1'b1;
        nxt_idx   = (XW+1)'(i);
      end
    end
  end

  assign cur = scan_q;
  always_comb begin
    if (cur < (XW+1)'(MaxLeft)) cv = CW'(cur);
    else cv = CW'(cur - (XW+1)'(MaxLeft));
  end

  assign status_o.walk_done = (pend_l_q == '0) && (pend_r_q == '0);
  assign status_o.scan_done = (scan_q == (XW+1)'(NV));
  assign status_o.emit_last = (total_q == '0) || (k_q + 6'd1 >= shown_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q   <= CW'(32 > MaxLeft ? MaxLeft : 32);
      rcnt_q   <= CW'(32 > MaxRight ? MaxRight : 32);
      lmatch_q <= '0;
      vl_q     <= '0;
      vr_q     <= '0;
      pend_l_q <= '0;
      pend_r_q <= '0;
      total_q  <= '0;
      shown_q  <= '0;
      k_q      <= '0;
      scan_q   <= '0;
      for (int i = 0; i < MaxLeft; i++) edge_q[i] <= '0;
      for (int i = 0; i < MaxRight; i++) part_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegLeftCount)
          lcnt_q <= (int'(cfg_data_i) > MaxLeft) ? CW'(MaxLeft) : CW'(cfg_data_i);
        else
          rcnt_q <= (int'(cfg_data_i) > MaxRight) ? CW'(MaxRight) : CW'(cfg_data_i);
      end
      case (cmd_i.op)
        DpLoad: begin
          case (cmd_e'(in_cmd_i))
            CmdClear: begin
              for (int i = 0; i < MaxLeft; i++) edge_q[i] <= '0;
              for (int i = 0; i < MaxRight; i++) part_q[i] <= '0;
              lmatch_q <= '0;
              vl_q     <= '0;
              vr_q     <= '0;
            end
            CmdAddEdge: begin
              if (in_ok)
                edge_q[in_l][in_r] <= 1'b1;
            end
            CmdAddPair: begin
              if (in_ok) begin
                for (int r = 0; r < MaxRight; r++)
                  if (part_q[r] == PW'(in_l) + PW'(1)) part_q[r] <= '0;
                part_q[in_r] <= PW'(in_l) + PW'(1);
                begin
                  logic [MaxLeft-1:0] m;
                  m = lmatch_q;
                  if (part_q[in_r] != '0)
                    m[part_q[in_r][LW-1:0] - LW'(1)] = 1'b0;
                  m[in_l] = 1'b1;
                  lmatch_q <= m;
                end
              end
            end
            default: begin
              vl_q <= '0;
            end
          endcase
        end
        DpStart: begin
          vl_q     <= lstart;
          vr_q     <= '0;
          pend_l_q <= lstart;
          pend_r_q <= '0;
          scan_q   <= '0;
          total_q  <= '0;
          k_q      <= '0;
        end
        DpWalk: begin
          if (pend_l_q != '0) begin
            vr_q            <= vr_q | nbr;
            pend_r_q        <= pend_r_q | nbr;
            pend_l_q[top_l] <= 1'b0;
          end else if (pend_r_q != '0) begin
            if (pl_ok) begin
              vl_q[pl]     <= 1'b1;
              pend_l_q[pl] <= 1'b1;
            end
            pend_r_q[top_r] <= 1'b0;
          end
        end
        DpCount: begin
          if (scan_q != (XW+1)'(NV)) begin
            if (cand[scan_q[XW-1:0]]) total_q <= total_q + TW'(1);
            scan_q <= scan_q + (XW+1)'(1);
          end else begin
            shown_q <= (int'(total_q) > OutLimit) ? 6'(OutLimit) : 6'(total_q);
            scan_q  <= nxt_found ? nxt_idx : '0;
          end
        end
        DpEmit: begin
          k_q <= k_q + 6'd1;
          if (nxt_found) scan_q <= nxt_idx;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    on_right_side_o = 1'b0;
    vertex_number_o = 5'(cv);
    if (total_q == '0) vertex_number_o = '0;
    else on_right_side_o = !(cur < (XW+1)'(MaxLeft));
    cover_size_o  = (int'(total_q) > 63) ? 6'd63 : 6'(total_q);
    empty_cover_o = (total_q == '0);
    last_o        = status_o.emit_last;
  end
endmodule

>>> hw/rtl/bipartite_min_vertex_cover.sv
// Konig minimum vertex cover of a stored bipartite graph and matching.
// Load commands: one item per cycle. Compute: a start step, then a walk that
// expands one pending vertex at a time, then a count scan over all
// MAX_LEFT+MAX_RIGHT vertex slots, then one result per cycle as taken.
// Input is held off from the compute item until its last result is taken.
// Active-low async reset clears the graph and sets counts to min(32, MAX_*).
module bipartite_min_vertex_cover #(
  parameter int MAX_LEFT  = 32,
  parameter int MAX_RIGHT = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmvc_in_if.sink   in_ch,
  bmvc_out_if.source out_ch,
  bmvc_cfg_if.sink  cfg_ch
);
  import bmvc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  bmvc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .in_cmd_i   (in_ch.command),
    .out_ready_i(out_ch.ready),
    .out_valid_o(out_ch.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bmvc_dp #(.MaxLeft(MAX_LEFT), .MaxRight(MAX_RIGHT)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .in_cmd_i       (in_ch.command),
    .in_left_i      (in_ch.left_vertex),
    .in_right_i     (in_ch.right_vertex),
    .cfg_we_i       (cfg_ch.valid),
    .cfg_index_i    (cfg_ch.index),
    .cfg_data_i     (cfg_ch.data),
    .status_o       (status),
    .on_right_side_o(out_ch.on_right_side),
    .vertex_number_o(out_ch.vertex_number),
    .cover_size_o   (out_ch.cover_size),
    .empty_cover_o  (out_ch.empty_cover),
    .last_o         (out_ch.last)
  );
endmodule

>>> tb/bipartite_min_vertex_cover_tb.sv
// Testbench for bipartite_min_vertex_cover: directed table then random graph
// sequences, checked item by item against a local cover predictor.
// Depends on bmvc_pkg, the bmvc channel interfaces and the block itself.
`timescale 1ns / 1ps

module bipartite_min_vertex_cover_tb;
  import bmvc_pkg::*;

  localparam int NumLeft   = 32;
  localparam int NumRight  = 32;
  localparam int StallMax  = 5000;
  localparam int SettleCyc = 400;

  typedef struct packed {
    logic       on_right;
    logic [4:0] vertex;
    logic [5:0] size;
    logic       empty;
    logic       last;
  } cover_item_t;

  typedef struct {
    cmd_e        cmd;
    logic [4:0]  lv;
    logic [4:0]  rv;
    bit          pinned;
    cover_item_t want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;

  bmvc_in_if  in_ch ();
  bmvc_out_if out_ch ();
  bmvc_cfg_if cfg_ch ();

  bipartite_min_vertex_cover dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // graph mirror
  logic [31:0] edge_rows [NumLeft];
  logic [31:0] left_paired;
  logic [5:0]  right_mate [NumRight];
  int          left_cnt;
  int          right_cnt;

  cover_item_t cover_q [$];
  cover_item_t pinned_item;
  bit          pinned_pending;

  int  errors;
  int  idle_cycles;
  int  send_gap_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  int  items_sent;
  int  computes_seen;
  int  results_seen;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int clamp_count(logic [5:0] v);
    return (v > 6'd32) ? 32 : int'(v);
  endfunction

  task automatic mirror_clear();
    for (int i = 0; i < NumLeft; i++) edge_rows[i] = '0;
    for (int i = 0; i < NumRight; i++) right_mate[i] = '0;
    left_paired = '0;
  endtask

  function automatic int mate_of_left(int u);
    if (!left_paired[u]) return -1;
    for (int r = 0; r < right_cnt; r++)
      if (right_mate[r] == 6'(u + 1)) return r;
    return -1;
  endfunction

  task automatic predict_cover(ref cover_item_t res [$]);
    logic [31:0] seen_l;
    logic [31:0] seen_r;
    int          pending [$];
    int          x;
    int          u;
    int          total;
    int          shown;
    int          k;
    seen_l = '0;
    seen_r = '0;
    for (u = 0; u < left_cnt; u++)
      if (mate_of_left(u) < 0) begin
        seen_l[u] = 1'b1;
        pending.insert(pending.size(), u);
      end
    while (pending.size() > 0) begin
      x = pending.pop_back();
      if (x < NumLeft) begin
        for (int r = 0; r < right_cnt; r++) begin
          if (!edge_rows[x][r] || right_mate[r] == 6'(x + 1) || seen_r[r]) continue;
          seen_r[r] = 1'b1;
          pending.insert(pending.size(), NumLeft + r);
        end
      end else if (right_mate[x - NumLeft] != 0) begin
        u = int'(right_mate[x - NumLeft]) - 1;
        if (u < left_cnt && !seen_l[u]) begin
          seen_l[u] = 1'b1;
          pending.insert(pending.size(), u);
        end
      end
    end
    total = 0;
    for (u = 0; u < left_cnt; u++) if (!seen_l[u]) total++;
    for (int r = 0; r < right_cnt; r++) if (seen_r[r]) total++;
    if (total == 0) begin
      res.insert(res.size(), '{1'b0, 5'd0, 6'd0, 1'b1, 1'b1});
      return;
    end
    shown = (total > 32) ? 32 : total;
    k = 0;
    for (u = 0; u < left_cnt && k < shown; u++)
      if (!seen_l[u]) begin
        k++;
        res.insert(res.size(), '{1'b0, 5'(u), 6'(total), 1'b0, k == shown});
      end
    for (int r = 0; r < right_cnt && k < shown; r++)
      if (seen_r[r]) begin
        k++;
        res.insert(res.size(), '{1'b1, 5'(r), 6'(total), 1'b0, k == shown});
      end
  endtask

  task automatic apply_item(cmd_e cmd, int l, int r);
    cover_item_t fresh [$];
    case (cmd)
      CmdClear: mirror_clear();
      CmdAddEdge: edge_rows[l][r] = 1'b1;
      CmdAddPair: begin
        for (int i = 0; i < NumRight; i++)
          if (right_mate[i] == 6'(l + 1)) right_mate[i] = '0;
        if (right_mate[r] != 0) left_paired[right_mate[r] - 1] = 1'b0;
        right_mate[r] = 6'(l + 1);
        left_paired[l] = 1'b1;
      end
      default: begin
        computes_seen++;
        predict_cover(fresh);
        if (pinned_pending) begin
          pinned_pending = 1'b0;
          cover_q.insert(cover_q.size(), pinned_item);
        end else begin
          foreach (fresh[i]) cover_q.insert(cover_q.size(), fresh[i]);
        end
      end
    endcase
  endtask

  // accept monitor: update mirror, check results
  always @(posedge clk_i) begin
    cover_item_t got;
    cover_item_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        apply_item(cmd_e'(in_ch.command), int'(in_ch.left_vertex), int'(in_ch.right_vertex));
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == RegLeftCount) left_cnt = clamp_count(cfg_ch.data);
        else right_cnt = clamp_count(cfg_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = '{out_ch.on_right_side, out_ch.vertex_number, out_ch.cover_size,
                out_ch.empty_cover, out_ch.last};
        if (cover_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected cover item side=%0d vertex=%0d size=%0d empty=%0d last=%0d",
                   $realtime, got.on_right, got.vertex, got.size, got.empty, got.last);
        end else begin
          want = cover_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: cover item mismatch expected side=%0d vertex=%0d size=%0d empty=%0d last=%0d",
                     $realtime, want.on_right, want.vertex, want.size, want.empty, want.last);
            $display("%0t:                     actual   side=%0d vertex=%0d size=%0d empty=%0d last=%0d",
                     $realtime, got.on_right, got.vertex, got.size, got.empty, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallMax) begin
      $display("watchdog: no progress for %0d cycles", StallMax);
      $display("FAIL bipartite_min_vertex_cover");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(cmd_e cmd, int l, int r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.left_vertex  <= 5'(l);
    in_ch.right_vertex <= 5'(r);
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic write_count(logic idx, logic [5:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (cover_q.size() > 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int pick_vertex(int cnt);
    if ($urandom_range(7) == 0) return $urandom_range(31);
    return $urandom_range((cnt >= 31) ? 31 : cnt);
  endfunction

  task automatic random_graph();
    int n;
    if ($urandom_range(5) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(cmd_e'($urandom_range(3)), $urandom_range(31), $urandom_range(31));
    end
    send_item(CmdClear, $urandom_range(31), $urandom_range(31));
    n = $urandom_range(1, 10);
    repeat (n) send_item(CmdAddEdge, pick_vertex(left_cnt), pick_vertex(right_cnt));
    n = $urandom_range(0, 4);
    repeat (n) send_item(CmdAddPair, pick_vertex(left_cnt), pick_vertex(right_cnt));
    send_item(CmdCompute, $urandom_range(31), $urandom_range(31));
  endtask

  step_row_t steps [17] = '{
    '{CmdCompute, 5'd0,  5'd0,  1'b1, '{1'b0, 5'd0, 6'd0, 1'b1, 1'b1}},
    '{CmdAddEdge, 5'd0,  5'd0,  1'b0, '0},
    '{CmdAddEdge, 5'd31, 5'd31, 1'b0, '0},
    '{CmdAddPair, 5'd0,  5'd0,  1'b0, '0},
    '{CmdAddPair, 5'd31, 5'd31, 1'b0, '0},
    '{CmdCompute, 5'd31, 5'd31, 1'b0, '0},
    '{CmdAddPair, 5'd5,  5'd0,  1'b0, '0},
    '{CmdAddEdge, 5'd1,  5'd0,  1'b0, '0},
    '{CmdAddEdge, 5'd5,  5'd3,  1'b0, '0},
    '{CmdCompute, 5'd0,  5'd0,  1'b0, '0},
    '{CmdAddPair, 5'd5,  5'd31, 1'b0, '0},
    '{CmdAddEdge, 5'd2,  5'd31, 1'b0, '0},
    '{CmdAddPair, 5'd10, 5'd21, 1'b0, '0},
    '{CmdAddEdge, 5'd21, 5'd10, 1'b0, '0},
    '{CmdCompute, 5'd21, 5'd10, 1'b0, '0},
    '{CmdClear,   5'd31, 5'd31, 1'b0, '0},
    '{CmdCompute, 5'd0,  5'd0,  1'b1, '{1'b0, 5'd0, 6'd0, 1'b1, 1'b1}}
  };

  logic [5:0] left_sets  [4] = '{6'd32, 6'd1, 6'd0, 6'd63};
  logic [5:0] right_sets [4] = '{6'd32, 6'd1, 6'd5, 6'd63};
  int gap_sets   [4] = '{0, 49, 0, 21};
  int stall_sets [4] = '{0, 0, 49, 21};

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CmdAddEdge;
    in_ch.left_vertex  = '0;
    in_ch.right_vertex = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = RegLeftCount;
    cfg_ch.data     = '0;
    errors          = 0;
    idle_cycles     = 0;
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 0;
    items_sent      = 0;
    computes_seen   = 0;
    results_seen    = 0;
    pinned_pending  = 1'b0;
    left_cnt        = 32;
    right_cnt       = 32;
    mirror_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) begin
      if (steps[i].pinned) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (cover_q.size() > 0) @(posedge clk_i);
        pinned_item    = steps[i].want;
        pinned_pending = 1'b1;
      end
      send_item(steps[i].cmd, steps[i].lv, steps[i].rv);
    end

    for (int p = 0; p < 4; p++) begin
      write_count(RegLeftCount, left_sets[p]);
      write_count(RegRightCount, right_sets[p]);
      send_gap_pct   = gap_sets[p];
      recv_stall_pct = stall_sets[p];
      if (p == 0) begin
        hold_cycles = 600;
        repeat (8) send_item(CmdCompute, $urandom_range(31), $urandom_range(31));
      end
      repeat (3) random_graph();
    end
    write_count(RegLeftCount, 6'd7);
    write_count(RegRightCount, 6'd32);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (1) random_graph();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    while (cover_q.size() > 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    $display("Covered %0d items, %0d cover computations, %0d result items checked,",
             items_sent, computes_seen, results_seen);
    $display("across count settings 0, 1, 5, 7, 32 and clamped 63 with varied backpressure.");
    if (errors == 0) begin
      $display("PASS bipartite_min_vertex_cover");
    end else begin
      $display("FAIL bipartite_min_vertex_cover");
    end
    $finish;
  end
endmodule
